@@ rtl/ert_pkg.sv @@
// ----------------------------------------------------------------------------
// ert_pkg: shared types and constants of the exercise rep tracker
// field widths, register indexes and the records passed from front to back
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int NUM_CLASSES_DEF = 4;

    localparam int SCORE_W    = 16;
    localparam int CONF_W     = 16;
    localparam int BASE_W     = 2;
    localparam int MAP_W      = 12;
    localparam int EX_W       = 3;
    localparam int CNT_W      = 16;
    localparam int MAP_CLASSES = MAP_W / EX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_CLASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_EX_MAP   = 2'd2;

    // result beat: 44 bits of fields, padded to whole bytes
    localparam int RES_W      = EX_W + CNT_W + 1 + 1 + EX_W + CNT_W + 1 + EX_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 2;

    // classified frame handed from front to back
    typedef struct packed {
        logic            act;      // top score at or above the threshold
        logic            is_ex;    // top class maps to a known exercise
        logic            is_base;  // top class is the baseline class
        logic [EX_W-1:0] det;      // exercise id of the top class
    } t_cls;

    typedef struct packed {
        logic [EX_W-1:0]  new_session_exercise;
        logic             session_changed;
        logic [CNT_W-1:0] end_rep;
        logic [EX_W-1:0]  end_exercise;
        logic             rep_end;
        logic             rep_start;
        logic [CNT_W-1:0] rep_count;
        logic [EX_W-1:0]  exercise;
    } t_result;

endpackage

@@ rtl/exercise_rep_tracker.sv @@
// ----------------------------------------------------------------------------
// exercise_rep_tracker: rep counter driven by classifier frames
// takes one score per class each beat and reports session and rep events
// ----------------------------------------------------------------------------
// Each input beat carries one classifier frame. The top class (lowest index on
// a tie) is compared against confidence_min; below it the beat only reports
// the current session. Otherwise the class map decides baseline or exercise:
// baseline to exercise starts a rep, exercise back to baseline ends it and
// commits the count, another exercise in mid-rep switches the session. Every
// input beat gives exactly one output beat. The block takes one beat per
// cycle while the queue has room: the front classifies a frame in the cycle
// it is accepted and writes it into a two-entry queue; the back pops one
// entry per cycle unless the output beat is stalled, updates the session
// and loads the output register. Configuration is written through a plain
// write port and should only change while no beat is in flight.
// ----------------------------------------------------------------------------
module exercise_rep_tracker #(
    parameter int NUM_CLASSES = ert_pkg::NUM_CLASSES_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input frames
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // score_0 .. score_N-1, 16 bits each, score_0 lowest
    input  logic [NUM_CLASSES*ert_pkg::SCORE_W-1:0]  s_axis_tdata,
    // results
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // exercise, rep_count, rep_start, rep_end, end_exercise, end_rep,
    // session_changed, new_session_exercise, zero pad to 48 bits
    output logic [ert_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // configuration writes
    input  logic                                     i_cfg_we,
    input  logic [ert_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [ert_pkg::CFG_DATA_W-1:0]           i_cfg_wdata
);

    logic [ert_pkg::CONF_W-1:0] r_confidence_min;
    logic [ert_pkg::BASE_W-1:0] r_baseline_class;
    logic [ert_pkg::MAP_W-1:0]  r_class_exercise_map;

    ert_pkg::t_cls    front_cls;
    ert_pkg::t_cls    queue_cls;
    ert_pkg::t_result result;
    logic             queue_full;
    logic             queue_empty;
    logic             queue_pop;
    logic             push;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confidence_min     <= '0;
            r_baseline_class     <= '0;
            r_class_exercise_map <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ert_pkg::CFG_CONFIDENCE_MIN: begin
                    r_confidence_min <= i_cfg_wdata[ert_pkg::CONF_W-1:0];
                end
                ert_pkg::CFG_BASELINE_CLASS: begin
                    r_baseline_class <= i_cfg_wdata[ert_pkg::BASE_W-1:0];
                end
                ert_pkg::CFG_CLASS_EX_MAP: begin
                    r_class_exercise_map <= i_cfg_wdata[ert_pkg::MAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: argmax and classification of the accepted frame
    ert_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .i_scores            (s_axis_tdata),
        .i_confidence_min    (r_confidence_min),
        .i_baseline_class    (r_baseline_class),
        .i_class_exercise_map(r_class_exercise_map),
        .o_cls               (front_cls)
    );

    // ready only depends on queue space, never on the output side directly
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    ert_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_data  (queue_cls)
    );

    // back: session state and output register
    ert_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (queue_empty),
        .i_cls    (queue_cls),
        .o_pop    (queue_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // result struct is declared highest field first, so it packs lowest first
    assign m_axis_tdata = {{(ert_pkg::OUT_DATA_W - ert_pkg::RES_W){1'b0}}, result};

endmodule

@@ rtl/ert_front.sv @@
// ----------------------------------------------------------------------------
// ert_front: frame classifier
// picks the top class of a frame and classifies it against the configuration
// ----------------------------------------------------------------------------
module ert_front #(
    parameter int NUM_CLASSES = ert_pkg::NUM_CLASSES_DEF
) (
    input  logic [NUM_CLASSES*ert_pkg::SCORE_W-1:0] i_scores,
    input  logic [ert_pkg::CONF_W-1:0]              i_confidence_min,
    input  logic [ert_pkg::BASE_W-1:0]              i_baseline_class,
    input  logic [ert_pkg::MAP_W-1:0]               i_class_exercise_map,
    output ert_pkg::t_cls                           o_cls
);

    localparam int IDX_W = $clog2(NUM_CLASSES);
    localparam int CMP_W = (IDX_W > ert_pkg::BASE_W) ? IDX_W : ert_pkg::BASE_W;

    logic [ert_pkg::SCORE_W-1:0] best;
    logic [IDX_W-1:0]            top;
    logic [ert_pkg::EX_W-1:0]    det;

    // argmax, strict compare so the lowest index wins a tie
    always_comb begin
        best = i_scores[ert_pkg::SCORE_W-1:0];
        top  = '0;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            if (i_scores[i*ert_pkg::SCORE_W +: ert_pkg::SCORE_W] > best) begin
                best = i_scores[i*ert_pkg::SCORE_W +: ert_pkg::SCORE_W];
                top  = IDX_W'(i);
            end
        end
    end

    // classes beyond the map read as unknown
    always_comb begin
        det = '0;
        for (int i = 0; i < ert_pkg::MAP_CLASSES; i++) begin
            if (CMP_W'(top) == CMP_W'(i)) begin
                det = i_class_exercise_map[i*ert_pkg::EX_W +: ert_pkg::EX_W];
            end
        end
    end

    always_comb begin
        o_cls.act     = (best >= i_confidence_min);
        o_cls.is_ex   = (det != '0);
        o_cls.is_base = (CMP_W'(top) == CMP_W'(i_baseline_class));
        o_cls.det     = det;
    end

endmodule

@@ rtl/ert_fifo.sv @@
// ----------------------------------------------------------------------------
// ert_fifo: short queue of classified frames
// decouples the frame classifier from the session tracker
// ----------------------------------------------------------------------------
module ert_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ert_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ert_pkg::t_cls o_data
);

    localparam int PTR_W = $clog2(ert_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ert_pkg::FIFO_DEPTH + 1);

    ert_pkg::t_cls    r_mem [ert_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(ert_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(ert_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(ert_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/ert_back.sv @@
// ----------------------------------------------------------------------------
// ert_back: session and rep tracker
// applies classified frames to the session state and holds the result beat
// ----------------------------------------------------------------------------
module ert_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ert_pkg::t_cls   i_cls,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output ert_pkg::t_result o_result
);

    logic                        r_in_rep,   n_in_rep;
    logic [ert_pkg::EX_W-1:0]    r_sess_ex,  n_sess_ex;
    logic [ert_pkg::CNT_W-1:0]   r_reps,     n_reps;
    logic [ert_pkg::CNT_W-1:0]   r_pend,     n_pend;
    logic                        r_last_base, n_last_base;
    logic                        r_valid;
    ert_pkg::t_result            r_res,      n_res;
    logic [ert_pkg::CNT_W-1:0]   start_reps;

    assign o_pop    = !i_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_comb begin
        n_in_rep    = r_in_rep;
        n_sess_ex   = r_sess_ex;
        n_reps      = r_reps;
        n_pend      = r_pend;
        n_last_base = r_last_base;
        start_reps  = r_reps;

        // default: report the current session
        n_res           = '0;
        n_res.exercise  = r_sess_ex;
        n_res.rep_count = (r_sess_ex != '0) ? r_reps : '0;

        if (i_cls.act) begin
            if (r_in_rep) begin
                if (i_cls.is_ex && (i_cls.det != r_sess_ex) && !i_cls.is_base) begin
                    // another exercise mid-rep: new session, new rep
                    n_res.session_changed      = 1'b1;
                    n_res.new_session_exercise = i_cls.det;
                    n_res.rep_start            = 1'b1;
                    n_res.exercise             = i_cls.det;
                    n_res.rep_count            = '0;
                    n_sess_ex   = i_cls.det;
                    n_reps      = '0;
                    n_pend      = ert_pkg::CNT_W'(1);
                    n_in_rep    = 1'b1;
                    n_last_base = 1'b0;
                end else if (i_cls.is_base) begin
                    // back to baseline: commit the rep
                    n_res.rep_end      = 1'b1;
                    n_res.end_exercise = r_sess_ex;
                    n_res.end_rep      = r_pend;
                    n_res.exercise     = r_sess_ex;
                    n_res.rep_count    = r_pend;
                    n_reps      = r_pend;
                    n_pend      = '0;
                    n_in_rep    = 1'b0;
                    n_last_base = 1'b1;
                end
            end else if (i_cls.is_base) begin
                n_last_base = 1'b1;
            end else if (i_cls.is_ex && r_last_base) begin
                if ((r_sess_ex != '0) && (r_sess_ex != i_cls.det)) begin
                    n_res.session_changed      = 1'b1;
                    n_res.new_session_exercise = i_cls.det;
                    start_reps                 = '0;
                end
                n_res.rep_start = 1'b1;
                n_res.exercise  = i_cls.det;
                n_res.rep_count = start_reps;
                n_sess_ex   = i_cls.det;
                n_reps      = start_reps;
                n_pend      = start_reps + 1'b1;
                n_in_rep    = 1'b1;
                n_last_base = 1'b0;
            end else if (i_cls.is_ex) begin
                n_last_base = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rep    <= 1'b0;
            r_sess_ex   <= '0;
            r_reps      <= '0;
            r_pend      <= '0;
            r_last_base <= 1'b1;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_rep    <= n_in_rep;
                r_sess_ex   <= n_sess_ex;
                r_reps      <= n_reps;
                r_pend      <= n_pend;
                r_last_base <= n_last_base;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule
